[rtl/akdd_pkg.sv]
// package for the analog keypad decoder with debounce
// holds the sizes, key codes and threshold reset values shared by the rtl
// no dependencies
package akdd_pkg;

  localparam int unsigned StableCount = 20;
  localparam int unsigned NumLevels   = 16;
  localparam int unsigned NumRegs     = 8;
  localparam int unsigned RegWidth    = 16;
  localparam int unsigned RegIdxWidth = $clog2(NumRegs);
  localparam int unsigned KeyWidth    = 5;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned SampleWidth = 8;
  localparam int unsigned InBytes     = (SampleWidth + 7) / 8;
  localparam int unsigned OutBits     = 15;
  localparam int unsigned OutBytes    = (OutBits + 7) / 8;

  typedef logic [KeyWidth-1:0]    key_t;
  typedef logic [CountWidth-1:0]  count_t;
  typedef logic [RegWidth-1:0]    reg_t;
  typedef logic [RegIdxWidth-1:0] reg_idx_t;

  localparam key_t   KeyNone        = key_t'(16);
  localparam count_t StableCountVal = count_t'(StableCount);

  localparam reg_t RegReset [NumRegs] = '{
    16'h1406, 16'h3223, 16'h5142, 16'h6E5F,
    16'h8B7D, 16'hA899, 16'hC5B6, 16'hE7D3
  };

endpackage

[rtl/analog_keypad_decode_debounce_top.sv]
// top level of the analog keypad decoder with debounce
// decodes adc samples to keys, debounces them and raises press and release events
// depends on akdd_pkg
//
// usage:
//   s_axis carries one adc sample per transaction (upper eight bits of a
//   conversion). m_axis returns one result per sample: the key decoded from
//   it and any press or release event confirmed on it.
//   the cfg port writes the eight threshold registers, two keys per register;
//   it is to be written only while no transaction is in flight, which the
//   block does not enforce. a result is registered on m_axis the cycle after
//   its sample is accepted. throughput is one sample per cycle while the
//   receiver takes results: decode, run counter update and event logic sit
//   in one stage in front of the result register. when the receiver stalls,
//   the result register holds and s_axis_tready drops until the result is
//   taken; a result taken in the same cycle lets a new sample in at once.
//   reset restores the threshold defaults, sets previous and confirmed key
//   to no key, clears the run counter and empties the result register.
module analog_keypad_decode_debounce_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample [7:0]
  input  logic [8*akdd_pkg::InBytes-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // current_key [4:0], press_valid [5], press_key [9:6],
  // release_valid [10], release_key [14:11], zero [15]
  output logic [8*akdd_pkg::OutBytes-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [akdd_pkg::RegIdxWidth-1:0]    cfg_index_i,
  input  logic [akdd_pkg::RegWidth-1:0]       cfg_data_i
);

  akdd_pkg::reg_t   thr_q [akdd_pkg::NumRegs];
  logic [akdd_pkg::NumRegs*akdd_pkg::RegWidth-1:0] thr_flat;

  akdd_pkg::key_t   prev_key_q, prev_key_d;
  akdd_pkg::key_t   conf_key_q, conf_key_d;
  akdd_pkg::count_t run_cnt_q, run_cnt_d;

  logic             out_valid_q;
  logic [8*akdd_pkg::OutBytes-1:0] out_data_q, out_data_d;

  logic [akdd_pkg::SampleWidth-1:0] sample;
  akdd_pkg::key_t   key;
  logic [akdd_pkg::CountWidth:0] run_inc;
  logic             press_valid, release_valid;
  logic [3:0]       press_key, release_key;
  logic             in_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sample        = s_axis_tdata[akdd_pkg::SampleWidth-1:0];

  always_comb begin
    for (int i = 0; i < akdd_pkg::NumRegs; i++) begin
      thr_flat[i*akdd_pkg::RegWidth +: akdd_pkg::RegWidth] = thr_q[i];
    end
  end

  // first threshold above the sample wins
  always_comb begin
    key = akdd_pkg::KeyNone;
    for (int k = akdd_pkg::NumLevels - 1; k >= 0; k--) begin
      if (sample < thr_flat[k*8 +: 8]) begin
        key = akdd_pkg::key_t'(k);
      end
    end
  end

  always_comb begin
    prev_key_d    = prev_key_q;
    conf_key_d    = conf_key_q;
    run_cnt_d     = run_cnt_q;
    press_valid   = 1'b0;
    press_key     = '0;
    release_valid = 1'b0;
    release_key   = '0;
    run_inc       = {1'b0, run_cnt_q} + 1'b1;
    if (key == prev_key_q) begin
      if (run_inc > {1'b0, akdd_pkg::StableCountVal}) begin
        run_cnt_d = akdd_pkg::StableCountVal;
      end else begin
        run_cnt_d = run_inc[akdd_pkg::CountWidth-1:0];
        if (run_inc == {1'b0, akdd_pkg::StableCountVal}) begin
          if (conf_key_q == akdd_pkg::KeyNone) begin
            if (key != akdd_pkg::KeyNone) begin
              press_valid = 1'b1;
              press_key   = key[3:0];
            end
          end else begin
            release_valid = 1'b1;
            release_key   = conf_key_q[3:0];
          end
          conf_key_d = key;
        end
      end
    end else begin
      if (conf_key_q == akdd_pkg::KeyNone || conf_key_q != key) begin
        run_cnt_d = akdd_pkg::count_t'(1);
      end
      prev_key_d = key;
    end
    out_data_d = {1'b0, release_key, release_valid, press_key, press_valid, key};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < akdd_pkg::NumRegs; i++) begin
        thr_q[i] <= akdd_pkg::RegReset[i];
      end
    end else if (cfg_we_i) begin
      thr_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_key_q  <= akdd_pkg::KeyNone;
      conf_key_q  <= akdd_pkg::KeyNone;
      run_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        prev_key_q  <= prev_key_d;
        conf_key_q  <= conf_key_d;
        run_cnt_q   <= run_cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_run_cnt_bounded : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    run_cnt_q <= akdd_pkg::StableCountVal
  ) else $error("run counter beyond stable count");

  a_events_exclusive : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[10])
  ) else $error("press and release in one result");

  a_press_is_current : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[4:0] == {1'b0, m_axis_tdata[9:6]})
  ) else $error("press key differs from decoded key");

  a_confirm_on_event : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (press_valid || release_valid)) |=> (conf_key_q == prev_key_q)
  ) else $error("event without matching confirmed key");

endmodule

[tb/analog_keypad_decode_debounce_top_test.sv]
// self-checking testbench for analog_keypad_decode_debounce_top
// directed table then random key runs over several threshold sets and flow-control phases
// depends on akdd_pkg and the top level rtl
`timescale 1ns / 100ps

module analog_keypad_decode_debounce_top_test;
  import akdd_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned NumPhases     = 7;
  localparam int unsigned PressurePhase = 5;

  typedef enum logic [2:0] {
    CfgDefault, CfgAscending, CfgShuffled, CfgAllZero, CfgAllOnes
  } cfg_kind_e;

  typedef enum logic [1:0] {
    IdleNone, IdleSender, IdleReceiver, IdleBoth
  } idle_mode_e;

  // laid out as m_axis_tdata[14:0]
  typedef struct packed {
    logic [3:0] release_key;
    logic       release_valid;
    logic [3:0] press_key;
    logic       press_valid;
    key_t       cur_key;
  } key_event_t;

  typedef struct packed {
    logic [7:0] smp;
    logic [5:0] reps;
    logic       typed;
    key_event_t ev;
  } directed_row_t;

  // typed results: release key, release, press key, press, decoded key
  localparam directed_row_t DirectedRows [20] = '{
    '{8'd255, 6'd1,  1'b1, '{4'd0, 1'b0, 4'd0, 1'b0, KeyNone}},
    '{8'd0,   6'd1,  1'b1, '{4'd0, 1'b0, 4'd0, 1'b0, 5'd0}},
    '{8'd230, 6'd1,  1'b1, '{4'd0, 1'b0, 4'd0, 1'b0, 5'd15}},
    '{8'd231, 6'd1,  1'b1, '{4'd0, 1'b0, 4'd0, 1'b0, KeyNone}},
    '{8'd19,  6'd1,  1'b0, '0},
    '{8'd20,  6'd1,  1'b0, '0},
    '{8'd127, 6'd1,  1'b0, '0},
    '{8'd128, 6'd1,  1'b0, '0},
    '{8'd85,  6'd1,  1'b0, '0},
    '{8'd170, 6'd1,  1'b0, '0},
    '{8'd210, 6'd1,  1'b0, '0},
    '{8'd0,   6'd20, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b1, 5'd0}},
    '{8'd255, 6'd20, 1'b1, '{4'd0, 1'b1, 4'd0, 1'b0, KeyNone}},
    '{8'd100, 6'd20, 1'b1, '{4'd0, 1'b0, 4'd7, 1'b1, 5'd7}},
    '{8'd200, 6'd3,  1'b0, '0},
    '{8'd100, 6'd18, 1'b1, '{4'd7, 1'b1, 4'd0, 1'b0, 5'd7}},
    '{8'd255, 6'd20, 1'b1, '{4'd7, 1'b1, 4'd0, 1'b0, KeyNone}},
    '{8'd0,   6'd1,  1'b0, '0},
    '{8'd255, 6'd20, 1'b1, '{4'd0, 1'b0, 4'd0, 1'b0, KeyNone}},
    '{8'd255, 6'd3,  1'b1, '{4'd0, 1'b0, 4'd0, 1'b0, KeyNone}}
  };

  localparam cfg_kind_e PhaseCfg [NumPhases] = '{
    CfgDefault, CfgAscending, CfgShuffled, CfgAllZero, CfgAllOnes, CfgAscending, CfgDefault
  };
  localparam idle_mode_e PhaseIdle [NumPhases] = '{
    IdleNone, IdleSender, IdleReceiver, IdleBoth, IdleNone, IdleNone, IdleBoth
  };
  localparam int unsigned PhaseItems [NumPhases] = '{150, 150, 150, 80, 80, 120, 150};

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [8*InBytes-1:0]        s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [8*OutBytes-1:0]       m_axis_tdata;
  logic                        cfg_we_i = 1'b0;
  logic [RegIdxWidth-1:0]      cfg_index_i = '0;
  logic [RegWidth-1:0]         cfg_data_i = '0;

  // predictor state
  reg_t   thr_regs [NumRegs] = RegReset;
  key_t   prev_key = KeyNone;
  key_t   conf_key = KeyNone;
  count_t run_cnt  = '0;

  key_event_t  pending_events [$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  analog_keypad_decode_debounce_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic key_event_t predict_key_event(input logic [7:0] smp);
    key_event_t  ev;
    key_t        key;
    int unsigned n;
    ev  = '0;
    key = KeyNone;
    // scan downwards so the lowest matching key wins
    for (int k = NumLevels - 1; k >= 0; k--) begin
      if (smp < thr_regs[k / 2][8 * (k % 2) +: 8]) key = key_t'(k);
    end
    ev.cur_key = key;
    if (key == prev_key) begin
      n = run_cnt + 1;
      if (n > StableCount) begin
        run_cnt = StableCountVal;
      end else begin
        run_cnt = count_t'(n);
        if (n == StableCount) begin
          if (conf_key == KeyNone) begin
            if (key != KeyNone) begin
              ev.press_valid = 1'b1;
              ev.press_key   = key[3:0];
            end
          end else begin
            ev.release_valid = 1'b1;
            ev.release_key   = conf_key[3:0];
          end
          conf_key = key;
        end
      end
    end else begin
      if (conf_key == KeyNone || conf_key != key) run_cnt = count_t'(1);
      prev_key = key;
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t mismatch on %s: got %0d, wanted %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_sample(input logic [7:0] smp, input bit typed, input key_event_t typed_ev);
    key_event_t ev;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    ev = predict_key_event(smp);
    pending_events.push_back(typed ? typed_ev : ev);
  endtask

  // runs of one sample with some bounce, short glitches and returns to an older key
  task automatic send_random_runs(input int unsigned count);
    logic [7:0]  smp;
    logic [7:0]  older;
    logic [7:0]  newer;
    int unsigned len;
    int unsigned done;
    older = 8'($urandom_range(255, 0));
    newer = 8'($urandom_range(255, 0));
    done  = 0;
    while (done < count) begin
      smp = ($urandom_range(3, 0) == 0) ? older : 8'($urandom_range(255, 0));
      len = ($urandom_range(3, 0) == 0) ? $urandom_range(5, 1) : $urandom_range(30, 18);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(39, 0) == 0) send_sample(8'($urandom_range(255, 0)), 1'b0, '0);
        else send_sample(smp, 1'b0, '0);
      end
      done += len;
      older = newer;
      newer = smp;
    end
  endtask

  task automatic load_thresholds(input cfg_kind_e kind);
    reg_t        value;
    int unsigned level;
    level = $urandom_range(40, 0);
    for (int r = 0; r < NumRegs; r++) begin
      case (kind)
        CfgDefault:  value = RegReset[r];
        CfgAllZero:  value = '0;
        CfgAllOnes:  value = '1;
        CfgShuffled: value = reg_t'($urandom_range(16'hffff, 0));
        CfgAscending: begin
          value[7:0] = 8'(level);
          level += $urandom_range(20, 1);
          if (level > 255) level = 255;
          value[15:8] = 8'(level);
          level += $urandom_range(20, 1);
          if (level > 255) level = 255;
        end
        default: value = RegReset[r];
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_idx_t'(r);
      cfg_data_i  <= value;
      thr_regs[r] = value;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // result side flow control, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // handshakes are stable between the falling edge and the next rising edge
  always @(negedge clk_i) begin
    key_event_t got;
    key_event_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = key_event_t'(m_axis_tdata[14:0]);
        if (pending_events.size() == 0) begin
          report_mismatch("unexpected transaction", int'(got), 0);
        end else begin
          want = pending_events.pop_front();
          if (got.cur_key !== want.cur_key)
            report_mismatch("current_key", int'(got.cur_key), int'(want.cur_key));
          if (got.press_valid !== want.press_valid)
            report_mismatch("press_valid", int'(got.press_valid), int'(want.press_valid));
          if (got.press_key !== want.press_key)
            report_mismatch("press_key", int'(got.press_key), int'(want.press_key));
          if (got.release_valid !== want.release_valid)
            report_mismatch("release_valid", int'(got.release_valid),
                            int'(want.release_valid));
          if (got.release_key !== want.release_key)
            report_mismatch("release_key", int'(got.release_key), int'(want.release_key));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      for (int r = 1; r <= DirectedRows[i].reps; r++) begin
        send_sample(DirectedRows[i].smp, DirectedRows[i].typed && r == DirectedRows[i].reps,
                    DirectedRows[i].ev);
      end
    end
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      load_thresholds(PhaseCfg[p]);
      case (PhaseIdle[p])
        IdleSender:   begin sender_idle_pct = 80; recv_stall_pct = 0;  end
        IdleReceiver: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
        IdleBoth:     begin sender_idle_pct = 15; recv_stall_pct = 15; end
        default:      begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (p == PressurePhase) hold_req = 1'b1;
      send_random_runs(PhaseItems[p]);
      wait_drained();
    end

    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
